// File: hw/rtl/gpb_pkg.sv
// ----------------------------------------------------------------------------
// gpb_pkg
// Shared types, constants and the restoring division step of the grey
// posterize blend block.
// ----------------------------------------------------------------------------
`default_nettype none

package gpb_pkg;

  localparam int unsigned LUMA_SUM_W = 20;
  localparam logic [LUMA_SUM_W-1:0] LUMA_KR = 20'd872;
  localparam logic [LUMA_SUM_W-1:0] LUMA_KG = 20'd2930;
  localparam logic [LUMA_SUM_W-1:0] LUMA_KB = 20'd296;

  localparam logic [6:0] MIX_FULL = 7'd64;
  localparam logic [7:0] GREY_MAX = 8'd255;

  localparam logic FMT_RGB888 = 1'b0;
  localparam logic FMT_RGB565 = 1'b1;

  localparam logic [1:0] REG_LEVELS    = 2'd0;
  localparam logic [1:0] REG_SMOOTH    = 2'd1;
  localparam logic [1:0] REG_INTENSITY = 2'd2;
  localparam logic [1:0] REG_FORMAT    = 2'd3;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  typedef struct packed {
    pix_t       pix;
    logic [7:0] luma;
  } luma_t;

  typedef struct packed {
    pix_t       pix;
    logic [7:0] q;
  } grey_t;

  typedef struct packed {
    logic       bypass;
    logic       fmt;
    logic [6:0] weight;
    logic [7:0] run;
    logic [7:0] step;
    logic [7:0] thr;
  } cfg_t;

  // One restoring division step: returns the new remainder and the quotient bit.
  function automatic logic [8:0] div_step(input logic [7:0] rem, input logic din,
                                          input logic [7:0] d);
    logic [8:0] sh;
    logic [8:0] res;
    sh = {rem, din};
    if (sh >= {1'b0, d}) begin
      res = {8'(sh - {1'b0, d}), 1'b1};
    end else begin
      res = {sh[7:0], 1'b0};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/grey_posterize_blend_top.sv
// ----------------------------------------------------------------------------
// grey_posterize_blend_top
// Greyscale conversion with optional posterization, blended back into the
// original color, for RGB888 or packed RGB565 pixels.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while the divider is idle and the output
// accepts, and returns each result through a six-stage pipeline (unpack, luma
// sum, two division halves, grey mapping, blend) in which back-pressure from
// the output side holds a full stage whose successor cannot take its data.
// After reset and after every write of the level count, the input stays not
// ready while a bit-serial divider derives the posterization run and step.
`default_nettype none

module grey_posterize_blend_top
  import gpb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // red_in, green_in, blue_in, packed_in
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // red_out, green_out, blue_out, packed_out
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  cfg_t  cfg;
  logic  busy;
  logic  luma_in_ready;
  logic  luma_vld;
  luma_t luma_data;
  logic  quant_ready;
  logic  grey_vld;
  grey_t grey_data;
  logic  blend_ready;

  assign cfg_pready = 1'b1;

  gpb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg),
    .busy    (busy)
  );

  assign in_tready = luma_in_ready && !busy;

  gpb_luma u_luma (
    .clk       (clk),
    .rst_n     (rst_n),
    .fmt       (cfg.fmt),
    .in_valid  (in_tvalid && !busy),
    .in_ready  (luma_in_ready),
    .in_data   (in_tdata),
    .out_valid (luma_vld),
    .out_ready (quant_ready),
    .out_data  (luma_data)
  );

  gpb_quant u_quant (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (luma_vld),
    .in_ready  (quant_ready),
    .in_data   (luma_data),
    .out_valid (grey_vld),
    .out_ready (blend_ready),
    .out_data  (grey_data)
  );

  gpb_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (grey_vld),
    .in_ready  (blend_ready),
    .in_data   (grey_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

`default_nettype wire

// File: hw/rtl/gpb_cfg.sv
// ----------------------------------------------------------------------------
// gpb_cfg
// Register file with the bus port and a bit-serial divider that derives the
// posterization run, step and threshold from the level count.
// ----------------------------------------------------------------------------
`default_nettype none

module gpb_cfg
  import gpb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output cfg_t             cfg,
  output logic             busy
);

  localparam logic [3:0] CNT_LAST      = 4'd9;

  logic [8:0] levels_r;
  logic       smooth_r;
  logic [6:0] intensity_r;
  logic       fmt_r;
  logic       busy_r;
  logic [3:0] cnt_r;
  logic [7:0] run_rem_r;
  logic [7:0] step_rem_r;
  logic [7:0] run_r;
  logic [7:0] step_r;
  logic [7:0] thr_r;

  logic       wr;
  logic       lv_wr;
  logic [7:0] lv;
  logic [7:0] lvm1;
  logic [8:0] run_nxt;
  logic [8:0] step_nxt;
  logic [15:0] thr_full;

  assign wr    = psel && penable && pwrite;
  assign lv_wr = wr && (paddr[3:2] == REG_LEVELS);

  always_comb begin
    if (levels_r < 9'd2) begin
      lv = 8'd2;
    end else if (levels_r[8]) begin
      lv = 8'd255;
    end else begin
      lv = levels_r[7:0];
    end
  end

  assign lvm1     = lv - 8'd1;
  assign run_nxt  = div_step(run_rem_r, cnt_r == 4'd0, lv);
  assign step_nxt = div_step(step_rem_r, cnt_r == 4'd0, lvm1);
  assign thr_full = 16'(lvm1) * 16'(run_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r    <= 9'd2;
      smooth_r    <= 1'b1;
      intensity_r <= MIX_FULL;
      fmt_r       <= FMT_RGB888;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_LEVELS:    levels_r    <= pwdata[8:0];
        REG_SMOOTH:    smooth_r    <= pwdata[0];
        REG_INTENSITY: intensity_r <= pwdata[6:0];
        REG_FORMAT:    fmt_r       <= pwdata[0];
        default:       levels_r    <= levels_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || lv_wr) begin
      busy_r     <= 1'b1;
      cnt_r      <= 4'd0;
      run_rem_r  <= 8'd0;
      step_rem_r <= 8'd0;
    end else if (busy_r) begin
      if (cnt_r != CNT_LAST) begin
        run_rem_r  <= run_nxt[8:1];
        step_rem_r <= step_nxt[8:1];
        run_r      <= {run_r[6:0], run_nxt[0]};
        step_r     <= {step_r[6:0], step_nxt[0]};
        cnt_r      <= cnt_r + 4'd1;
      end else begin
        thr_r  <= thr_full[7:0];
        busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LEVELS:    prdata = {23'd0, levels_r};
      REG_SMOOTH:    prdata = {31'd0, smooth_r};
      REG_INTENSITY: prdata = {25'd0, intensity_r};
      REG_FORMAT:    prdata = {31'd0, fmt_r};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg.bypass = smooth_r || levels_r[8];
  assign cfg.fmt    = fmt_r;
  assign cfg.weight = (intensity_r > MIX_FULL) ? MIX_FULL : intensity_r;
  assign cfg.run    = run_r;
  assign cfg.step   = step_r;
  assign cfg.thr    = thr_r;
  assign busy       = busy_r;

  a_lv_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    lv_wr |=> busy_r && (cnt_r == 4'd0))
    else $error("divider did not restart after a level write");

  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && (cnt_r == CNT_LAST) && !lv_wr) |=> !busy_r)
    else $error("divider did not finish");

  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && (cnt_r != CNT_LAST)) |=> busy_r && (cnt_r <= CNT_LAST))
    else $error("divider stopped early");

endmodule

`default_nettype wire

// File: hw/rtl/gpb_luma.sv
// ----------------------------------------------------------------------------
// gpb_luma
// Two pipeline stages: pixel unpacking, then the weighted luma sum.
// ----------------------------------------------------------------------------
`default_nettype none

module gpb_luma
  import gpb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fmt,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [39:0] in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output luma_t            out_data
);

  logic  s1_vld_r;
  pix_t  s1_pix_r;
  logic  s2_vld_r;
  luma_t s2_r;
  logic  rdy1;
  logic  rdy2;
  pix_t  pix_nxt;
  logic [LUMA_SUM_W-1:0] sum_nxt;

  assign rdy2 = !s2_vld_r || out_ready;
  assign rdy1 = !s1_vld_r || rdy2;

  always_comb begin
    if (fmt == FMT_RGB565) begin
      pix_nxt.r = {in_data[39:35], 3'b000};
      pix_nxt.g = {in_data[34:29], 2'b00};
      pix_nxt.b = {in_data[28:24], 3'b000};
    end else begin
      pix_nxt.r = in_data[7:0];
      pix_nxt.g = in_data[15:8];
      pix_nxt.b = in_data[23:16];
    end
  end

  assign sum_nxt = LUMA_SUM_W'(s1_pix_r.r) * LUMA_KR
                 + LUMA_SUM_W'(s1_pix_r.g) * LUMA_KG
                 + LUMA_SUM_W'(s1_pix_r.b) * LUMA_KB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (rdy1) s1_vld_r <= in_valid;
      if (rdy2) s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) s1_pix_r <= pix_nxt;
    if (rdy2 && s1_vld_r) begin
      s2_r.pix  <= s1_pix_r;
      s2_r.luma <= sum_nxt[LUMA_SUM_W-1:12];
    end
  end

  assign in_ready  = rdy1;
  assign out_valid = s2_vld_r;
  assign out_data  = s2_r;

endmodule

`default_nettype wire

// File: hw/rtl/gpb_quant.sv
// ----------------------------------------------------------------------------
// gpb_quant
// Three pipeline stages: two halves of the luma-by-run division, then the
// mapping of the bucket index to its grey level.
// ----------------------------------------------------------------------------
`default_nettype none

module gpb_quant
  import gpb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  cfg_t      cfg,
  input  wire logic in_valid,
  output logic      in_ready,
  input  luma_t     in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output grey_t     out_data
);

  logic       s3_vld_r;
  luma_t      s3_r;
  logic [7:0] s3_rem_r;
  logic [3:0] s3_qhi_r;
  logic       s4_vld_r;
  luma_t      s4_r;
  logic [7:0] s4_quot_r;
  logic       s5_vld_r;
  grey_t      s5_r;
  logic       rdy3;
  logic       rdy4;
  logic       rdy5;

  logic [7:0] rem_hi [0:4];
  logic [7:0] rem_lo [0:4];
  logic [3:0] qhi_nxt;
  logic [3:0] qlo_nxt;
  logic [8:0] st_hi  [0:3];
  logic [8:0] st_lo  [0:3];
  logic [15:0] prod;
  logic [7:0] q_nxt;

  assign rdy5 = !s5_vld_r || out_ready;
  assign rdy4 = !s4_vld_r || rdy5;
  assign rdy3 = !s3_vld_r || rdy4;

  always_comb begin
    rem_hi[0] = 8'd0;
    for (int i = 0; i < 4; i++) begin
      st_hi[i]      = div_step(rem_hi[i], in_data.luma[7-i], cfg.run);
      rem_hi[i+1]   = st_hi[i][8:1];
      qhi_nxt[3-i]  = st_hi[i][0];
    end
  end

  always_comb begin
    rem_lo[0] = s3_rem_r;
    for (int i = 0; i < 4; i++) begin
      st_lo[i]      = div_step(rem_lo[i], s3_r.luma[3-i], cfg.run);
      rem_lo[i+1]   = st_lo[i][8:1];
      qlo_nxt[3-i]  = st_lo[i][0];
    end
  end

  assign prod = 16'(s4_quot_r) * 16'(cfg.step);

  always_comb begin
    if (cfg.bypass) begin
      q_nxt = s4_r.luma;
    end else if (s4_r.luma < cfg.thr) begin
      q_nxt = prod[7:0];
    end else begin
      q_nxt = GREY_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      if (rdy3) s3_vld_r <= in_valid;
      if (rdy4) s4_vld_r <= s3_vld_r;
      if (rdy5) s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && in_valid) begin
      s3_r     <= in_data;
      s3_rem_r <= rem_hi[4];
      s3_qhi_r <= qhi_nxt;
    end
    if (rdy4 && s3_vld_r) begin
      s4_r      <= s3_r;
      s4_quot_r <= {s3_qhi_r, qlo_nxt};
    end
    if (rdy5 && s4_vld_r) begin
      s5_r.pix <= s4_r.pix;
      s5_r.q   <= q_nxt;
    end
  end

  assign in_ready  = rdy3;
  assign out_valid = s5_vld_r;
  assign out_data  = s5_r;

endmodule

`default_nettype wire

// File: hw/rtl/gpb_blend.sv
// ----------------------------------------------------------------------------
// gpb_blend
// Output stage: mixes the grey level into each channel and packs the result
// word for the selected pixel format.
// ----------------------------------------------------------------------------
`default_nettype none

module gpb_blend
  import gpb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  cfg_t       cfg,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  grey_t      in_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [39:0] out_data
);

  logic        s6_vld_r;
  logic [39:0] s6_data_r;
  logic        rdy6;
  logic [6:0]  inv_w;
  logic [13:0] mix_r;
  logic [13:0] mix_g;
  logic [13:0] mix_b;
  logic [7:0]  ro;
  logic [7:0]  go;
  logic [7:0]  bo;
  logic [39:0] data_nxt;

  assign rdy6  = !s6_vld_r || out_ready;
  assign inv_w = MIX_FULL - cfg.weight;

  assign mix_r = 14'(in_data.q) * 14'(cfg.weight) + 14'(in_data.pix.r) * 14'(inv_w);
  assign mix_g = 14'(in_data.q) * 14'(cfg.weight) + 14'(in_data.pix.g) * 14'(inv_w);
  assign mix_b = 14'(in_data.q) * 14'(cfg.weight) + 14'(in_data.pix.b) * 14'(inv_w);

  assign ro = mix_r[13:6];
  assign go = mix_g[13:6];
  assign bo = mix_b[13:6];

  always_comb begin
    if (cfg.fmt == FMT_RGB565) begin
      data_nxt = {ro[7:3], go[7:2], bo[7:3], 24'd0};
    end else begin
      data_nxt = {16'd0, bo, go, ro};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (rdy6) begin
      s6_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6 && in_valid) s6_data_r <= data_nxt;
  end

  assign in_ready  = rdy6;
  assign out_valid = s6_vld_r;
  assign out_data  = s6_data_r;

endmodule

`default_nettype wire
